// ----- hw/rtl/fpsc_pkg.sv -----
`timescale 1ns / 1ps

package fpsc_pkg;

  // The window length must be a power of two; the mean is a shift.
  localparam int WINDOW_SIZE = 8;
  localparam int WIN_AW      = $clog2(WINDOW_SIZE);

  localparam int SAMPLE_W = 10;
  localparam int RAW_W    = 11;
  localparam int SUM_W    = SAMPLE_W + WIN_AW;
  localparam int MEAN_W   = SUM_W + 4;

  localparam int TGT_W    = 16;
  localparam int GAIN_W   = 16;
  localparam int LIM_W    = 10;
  localparam int INT_W    = 11;
  localparam int ERR_W    = 22;
  localparam int ERRO_W   = 17;
  localparam int DRIVE_W  = 7;

  localparam int MUL_AW   = ERR_W;
  localparam int MUL_BW   = GAIN_W + 1;
  localparam int PROD_W   = MUL_AW + MUL_BW;
  localparam int ACC_W    = PROD_W + 1;

  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 16;

  localparam logic [CFG_AW-1:0] CFG_GAIN_P    = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_GAIN_I    = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_INT_LIMIT = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_P_RST    = 16'd256;
  localparam logic [GAIN_W-1:0] GAIN_I_RST    = 16'd0;
  localparam logic [LIM_W-1:0]  INT_LIMIT_RST = 10'd10;

  localparam logic [MUL_BW-1:0]  SPEED_SCALE   = 17'd36;
  localparam logic [ERR_W-1:0]   ERR_RESET_Q4  = 22'd3200;
  localparam logic [DRIVE_W-1:0] DRIVE_MAX     = 7'd100;

  typedef struct packed {
    logic clear;
    logic shift;
  } win_ctl_t;

endpackage

// ----- hw/rtl/fpsc_in_if.sv -----
`timescale 1ns / 1ps

interface fpsc_in_if;
  import fpsc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [TGT_W-1:0]        speed_setpoint;
  logic signed [RAW_W-1:0] measured_velocity;

  modport source (output valid, output operation, output speed_setpoint,
                  output measured_velocity, input ready);
  modport sink (input valid, input operation, input speed_setpoint,
                input measured_velocity, output ready);
endinterface

// ----- hw/rtl/fpsc_out_if.sv -----
`timescale 1ns / 1ps

interface fpsc_out_if;
  import fpsc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [DRIVE_W-1:0]       drive;
  logic signed [ERRO_W-1:0] speed_error;
  logic signed [INT_W-1:0]  integral_value;

  modport source (output valid, output drive, output speed_error,
                  output integral_value, input ready);
  modport sink (input valid, input drive, input speed_error,
                input integral_value, output ready);
endinterface

// ----- hw/rtl/fpsc_mul.sv -----
`timescale 1ns / 1ps

module fpsc_mul (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [fpsc_pkg::MUL_AW-1:0]   op_a,
  input  logic signed [fpsc_pkg::MUL_BW-1:0]   op_b,
  output logic signed [fpsc_pkg::PROD_W-1:0]   prod
);
  import fpsc_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

  assign prod = prod_r;
endmodule

// ----- hw/rtl/fpsc_window.sv -----
`timescale 1ns / 1ps

module fpsc_window (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fpsc_pkg::win_ctl_t                  ctl,
  input  logic signed [fpsc_pkg::RAW_W-1:0]   sample,
  output logic [fpsc_pkg::SUM_W-1:0]          sum
);
  import fpsc_pkg::*;

  logic [SAMPLE_W-1:0] win_r [WINDOW_SIZE];
  logic [SUM_W-1:0]    sum_r;
  logic [RAW_W-1:0]    neg;
  logic [RAW_W-1:0]    abs_raw;
  logic [SAMPLE_W-1:0] mag;

  assign neg     = RAW_W'(-sample);
  assign abs_raw = sample[RAW_W-1] ? neg : RAW_W'(sample);
  assign mag     = abs_raw[RAW_W-1] ? {SAMPLE_W{1'b1}} : abs_raw[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int k = 0; k < WINDOW_SIZE; k++) begin
        win_r[k] <= '0;
      end
      sum_r <= '0;
    end else if (ctl.shift) begin
      for (int k = 0; k < WINDOW_SIZE - 1; k++) begin
        win_r[k] <= win_r[k+1];
      end
      win_r[WINDOW_SIZE-1] <= mag;
      sum_r <= sum_r - SUM_W'(win_r[0]) + SUM_W'(mag);
    end
  end

  assign sum = sum_r;
endmodule

// ----- hw/rtl/flywheel_pi_speed_controller.sv -----
`timescale 1ns / 1ps

// Channel   Dir   Payload                                        Transfer
// in_ch     in    operation, speed_setpoint, measured_velocity   valid && ready
// out_ch    out   drive, speed_error, integral_value             valid && ready
// cfg_*     in    cfg_addr, cfg_wdata                            cfg_we high
//
// Each tick passes through the states SPD, ERR, INT, PACC, IACC and DONE, where its
// result is registered; the shared multiplier is used three times per tick.
// Input is accepted only in the idle state, one tick at a time.
// A finished result waits in the output register, so a new tick may enter
// while it is held; a stalled result holds the sequencer at its last step.
// Reset is synchronous; it clears the window and integral and restores the configuration defaults.
module flywheel_pi_speed_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  fpsc_in_if.sink                       in_ch,
  fpsc_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [fpsc_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [fpsc_pkg::CFG_DW-1:0]   cfg_wdata
);
  import fpsc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SPD  = 3'd1;
  localparam logic [2:0] S_ERR  = 3'd2;
  localparam logic [2:0] S_INT  = 3'd3;
  localparam logic [2:0] S_PACC = 3'd4;
  localparam logic [2:0] S_IACC = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;

  logic [GAIN_W-1:0] gain_p_r, gain_i_r;
  logic [LIM_W-1:0]  lim_r;

  logic [TGT_W-1:0]        tgt_r;
  logic signed [RAW_W-1:0] smp_r;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic signed [INT_W-1:0] int_r, int_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  logic                     out_valid_r;
  logic [DRIVE_W-1:0]       drive_r, drive_nxt;
  logic signed [ERRO_W-1:0] erro_r, erro_nxt;
  logic signed [INT_W-1:0]  into_r;

  logic accept, out_free;
  win_ctl_t win_ctl;
  logic [SUM_W-1:0] win_sum;
  logic [MEAN_W-1:0] mean_q4;

  logic mul_en;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;

  logic signed [INT_W+1:0] step, lim_s;
  logic signed [ERR_W-1:0] err_neg;
  logic [ERR_W-1:0]        err_qneg;
  logic signed [ACC_W-1:0] dq;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  assign mean_q4 = MEAN_W'({win_sum, 4'b0} >> WIN_AW);

  assign win_ctl.clear = accept && in_ch.operation;
  assign win_ctl.shift = (state_r == S_DONE) && out_free;

  fpsc_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (win_ctl),
    .sample (smp_r),
    .sum    (win_sum)
  );

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_SPD: begin
        mul_en = 1'b1;
        mul_a  = MUL_AW'(signed'({1'b0, mean_q4}));
        mul_b  = SPEED_SCALE;
      end
      S_INT: begin
        mul_en = 1'b1;
        mul_a  = err_r;
        mul_b  = signed'({1'b0, gain_p_r});
      end
      S_PACC: begin
        mul_en = 1'b1;
        mul_a  = MUL_AW'(signed'({int_r, 4'b0}));
        mul_b  = signed'({1'b0, gain_i_r});
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  fpsc_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  always_comb begin
    lim_s = signed'({3'b0, lim_r});
    if (err_r > 0) begin
      step = (INT_W+2)'(int_r) + 13'sd1;
    end else if (err_r < 0) begin
      step = (INT_W+2)'(int_r) - 13'sd1;
    end else begin
      step = (INT_W+2)'(int_r);
    end
    if (step > lim_s) begin
      step = lim_s;
    end
    if (step < -lim_s) begin
      step = -lim_s;
    end
    if (err_r > signed'(ERR_RESET_Q4) || err_r < -signed'(ERR_RESET_Q4)) begin
      step = '0;
    end
  end

  always_comb begin
    err_neg  = -err_r;
    err_qneg = unsigned'(err_neg) >> 4;
    if (err_r >= 0) begin
      erro_nxt = ERRO_W'(err_r >>> 4);
    end else begin
      erro_nxt = ERRO_W'(-signed'(err_qneg));
    end
    dq = acc_r >>> 12;
    if (acc_r <= 0) begin
      drive_nxt = '0;
    end else if (dq > ACC_W'(DRIVE_MAX)) begin
      drive_nxt = DRIVE_MAX;
    end else begin
      drive_nxt = dq[DRIVE_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    int_nxt   = int_r;
    acc_nxt   = acc_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SPD;
          if (in_ch.operation) begin
            int_nxt = '0;
          end
        end
      end
      S_SPD: begin
        state_nxt = S_ERR;
      end
      S_ERR: begin
        err_nxt   = signed'({2'b0, tgt_r, 4'b0}) - ERR_W'(prod);
        state_nxt = S_INT;
      end
      S_INT: begin
        int_nxt   = INT_W'(step);
        state_nxt = S_PACC;
      end
      S_PACC: begin
        acc_nxt   = ACC_W'(prod);
        state_nxt = S_IACC;
      end
      S_IACC: begin
        acc_nxt   = acc_r + ACC_W'(prod);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      int_r       <= '0;
      out_valid_r <= 1'b0;
      gain_p_r    <= GAIN_P_RST;
      gain_i_r    <= GAIN_I_RST;
      lim_r       <= INT_LIMIT_RST;
    end else begin
      state_r <= state_nxt;
      int_r   <= int_nxt;
      if (win_ctl.shift) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_GAIN_P:    gain_p_r <= cfg_wdata[GAIN_W-1:0];
          CFG_GAIN_I:    gain_i_r <= cfg_wdata[GAIN_W-1:0];
          CFG_INT_LIMIT: lim_r    <= cfg_wdata[LIM_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    err_r <= err_nxt;
    acc_r <= acc_nxt;
    if (accept) begin
      tgt_r <= in_ch.speed_setpoint;
      smp_r <= in_ch.measured_velocity;
    end
    if (win_ctl.shift) begin
      drive_r <= drive_nxt;
      erro_r  <= erro_nxt;
      into_r  <= int_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.drive          = drive_r;
  assign out_ch.speed_error    = erro_r;
  assign out_ch.integral_value = into_r;

  a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_SPD)
    else $error("accepted tick did not start the sequence");

  a_restart_clears : assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.operation |=> win_sum == '0 && int_r == '0)
    else $error("restart did not clear window and integral");

  a_int_clamped : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INT |=> int_r <= signed'({1'b0, lim_r}) && int_r >= -signed'({1'b0, lim_r}))
    else $error("integral outside its limit");

  a_drive_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> drive_r <= DRIVE_MAX)
    else $error("drive above its maximum");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> !(state_r == S_IDLE && $past(state_r) == S_DONE))
    else $error("result overwritten while stalled");

endmodule

// ----- tb/flywheel_pi_speed_controller_tb.sv -----
`timescale 1ns / 1ps

module flywheel_pi_speed_controller_tb;
  import fpsc_pkg::*;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [CFG_AW-1:0] CFG_UNUSED = 2'd3;

  localparam int SPEED_MUL   = 36;
  localparam int ERR_BAND_Q4 = 200 * 16;
  localparam int DRIVE_TOP   = 100;
  localparam int SETTLE      = 12;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    logic [DRIVE_W-1:0]       drive;
    logic signed [ERRO_W-1:0] speed_error;
    logic signed [INT_W-1:0]  integral_value;
  } tick_result_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [CFG_DW-1:0]   cfg_wdata;

  fpsc_in_if  in_ch ();
  fpsc_out_if out_ch ();

  flywheel_pi_speed_controller DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Controller state as the design should hold it.
  int kp_reg;
  int ki_reg;
  int ilim_reg;
  int win_samples [WINDOW_SIZE];
  int win_total;
  int integ_count;

  tick_result_t pending_results [$];
  int           mismatch_count = 0;
  int           ticks_sent;
  int           sink_hold;
  logic         src_calm;
  logic         snk_calm;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap(input logic calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic reset_model();
    kp_reg   = int'(GAIN_P_RST);
    ki_reg   = int'(GAIN_I_RST);
    ilim_reg = int'(INT_LIMIT_RST);
    foreach (win_samples[k]) win_samples[k] = 0;
    win_total   = 0;
    integ_count = 0;
  endtask

  task automatic compute_tick(input logic op, input logic [TGT_W-1:0] tgt,
                              input logic signed [RAW_W-1:0] vel,
                              output tick_result_t res);
    longint err_q4;
    longint mean_q4;
    longint acc;
    longint err_whole;
    longint d;
    int     mag;
    if (op == OP_RESTART) begin
      integ_count = 0;
      foreach (win_samples[k]) win_samples[k] = 0;
      win_total = 0;
    end
    mean_q4 = (longint'(win_total) * 16) / WINDOW_SIZE;
    err_q4  = longint'(tgt) * 16 - mean_q4 * SPEED_MUL;
    if (err_q4 > 0) integ_count++;
    else if (err_q4 < 0) integ_count--;
    if (integ_count > ilim_reg) integ_count = ilim_reg;
    if (integ_count < -ilim_reg) integ_count = -ilim_reg;
    if (err_q4 > ERR_BAND_Q4 || err_q4 < -ERR_BAND_Q4) integ_count = 0;
    acc = longint'(kp_reg) * err_q4 + longint'(ki_reg) * longint'(integ_count) * 16;
    if (acc <= 0) begin
      res.drive = '0;
    end else begin
      d = acc / 4096;
      res.drive = (d > DRIVE_TOP) ? DRIVE_W'(DRIVE_TOP) : d[DRIVE_W-1:0];
    end
    mag = int'(vel);
    if (mag < 0) mag = -mag;
    if (mag > 1023) mag = 1023;
    win_total -= win_samples[0];
    for (int k = 0; k < WINDOW_SIZE - 1; k++) win_samples[k] = win_samples[k + 1];
    win_samples[WINDOW_SIZE - 1] = mag;
    win_total += mag;
    err_whole = (err_q4 >= 0) ? err_q4 / 16 : -((-err_q4) / 16);
    res.speed_error    = err_whole[ERRO_W-1:0];
    res.integral_value = integ_count[INT_W-1:0];
  endtask

  task automatic send_tick(input logic op, input logic [TGT_W-1:0] tgt,
                           input logic signed [RAW_W-1:0] vel);
    int           gap;
    tick_result_t res;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.operation         <= op;
    in_ch.speed_setpoint    <= tgt;
    in_ch.measured_velocity <= vel;
    do @(posedge clk); while (!in_ch.ready);
    compute_tick(op, tgt, vel, res);
    pending_results.push_back(res);
    ticks_sent++;
  endtask

  task automatic wait_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_GAIN_P:    kp_reg   = int'(val);
      CFG_GAIN_I:    ki_reg   = int'(val);
      CFG_INT_LIMIT: ilim_reg = int'(val[LIM_W-1:0]);
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_gains(input int kp, input int ki, input int lim);
    wait_results();
    cfg_write(CFG_GAIN_P, kp[CFG_DW-1:0]);
    cfg_write(CFG_GAIN_I, ki[CFG_DW-1:0]);
    cfg_write(CFG_INT_LIMIT, lim[CFG_DW-1:0]);
  endtask

  task automatic test_reset_config();
    send_tick(OP_TICK, 16'd0, 11'sd0);
    send_tick(OP_TICK, 16'hFFFF, 11'sd1023);
    send_tick(OP_TICK, 16'd0, 11'h400);
    send_tick(OP_TICK, 16'd100, -11'sd1);
    send_tick(OP_RESTART, 16'd5, 11'sd0);
  endtask

  // A single sample of one leaves a small negative error that must truncate
  // toward zero; a sample of two with a target of nine gives an exact zero.
  task automatic test_error_rounding();
    send_tick(OP_RESTART, 16'd0, 11'sd1);
    send_tick(OP_TICK, 16'd0, 11'sd0);
    send_tick(OP_TICK, 16'd9, 11'sd0);
    send_tick(OP_RESTART, 16'd0, 11'sd2);
    send_tick(OP_TICK, 16'd9, 11'sd0);
  endtask

  task automatic test_integral_band();
    set_gains(256, 4096, 1023);
    send_tick(OP_RESTART, 16'd200, 11'sd0);
    send_tick(OP_TICK, 16'd200, 11'sd0);
    send_tick(OP_TICK, 16'd201, 11'sd0);
    send_tick(OP_RESTART, 16'd0, 11'sd46);
    send_tick(OP_TICK, 16'd7, 11'sd0);
  endtask

  // The integral is built past a limit that is then lowered underneath it.
  task automatic test_limit_lowering();
    send_tick(OP_RESTART, 16'd10, 11'sd0);
    repeat (6) send_tick(OP_TICK, 16'd10, 11'sd0);
    wait_results();
    cfg_write(CFG_INT_LIMIT, 16'd3);
    send_tick(OP_TICK, 16'd10, 11'sd0);
    wait_results();
    cfg_write(CFG_INT_LIMIT, 16'hFC05);
    cfg_write(CFG_UNUSED, 16'h1234);
    send_tick(OP_TICK, 16'd10, 11'sd0);
  endtask

  task automatic test_extreme_gains();
    set_gains(65535, 65535, 1023);
    send_tick(OP_TICK, 16'hFFFF, -11'sd1023);
    send_tick(OP_TICK, 16'd0, 11'sd1023);
    send_tick(OP_RESTART, 16'd1, 11'h400);
  endtask

  task automatic test_random_ticks();
    int          kp;
    int          ki;
    int          lim;
    int          off;
    int          tgt_i;
    int          sel;
    logic        op;
    logic [10:0] vel;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin kp = 0; ki = 0; lim = 0; end
        1: begin kp = 65535; ki = 65535; lim = 1023; end
        default: begin
          kp  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 512);
          ki  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4096);
          lim = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 30);
        end
      endcase
      set_gains(kp, ki, lim);
      for (int n = 0; n < 225; n++) begin
        if (n % 50 == 0) begin
          src_calm = ($urandom_range(0, 3) == 0);
          snk_calm = ($urandom_range(0, 3) == 0);
        end
        if (n % 75 == 74) wait_results();
        op  = ($urandom_range(0, 99) < 3) ? OP_RESTART : OP_TICK;
        sel = $urandom_range(0, 9);
        if (sel < 6) vel = 11'($urandom_range(0, 2047));
        else if (sel < 9) vel = 11'(int'($urandom_range(0, 40)) - 20);
        else vel = ($urandom_range(0, 1) == 0) ? 11'h400 : 11'h3FF;
        sel = $urandom_range(0, 9);
        if (sel < 8) begin
          off   = (sel < 6) ? int'($urandom_range(0, 500)) - 250 : int'($urandom_range(0, 60)) - 30;
          tgt_i = (win_total * 9) / 2 + off;
          if (tgt_i < 0) tgt_i = 0;
          if (tgt_i > 65535) tgt_i = 65535;
        end else begin
          tgt_i = $urandom_range(0, 65535);
        end
        send_tick(op, tgt_i[TGT_W-1:0], vel);
      end
    end
    src_calm = 1'b0;
    snk_calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_hold    <= 0;
    end else if (sink_hold > 0) begin
      out_ch.ready <= 1'b0;
      sink_hold    <= sink_hold - 1;
    end else begin : pick_stall
      int n;
      n = pick_gap(snk_calm);
      if (n == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        sink_hold    <= n - 1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    tick_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("%0t: unexpected result drive=%0d error=%0d integral=%0d", $realtime,
                   out_ch.drive, out_ch.speed_error, out_ch.integral_value);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.drive !== want.drive || out_ch.speed_error !== want.speed_error ||
            out_ch.integral_value !== want.integral_value) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: mismatch exp drive=%0d error=%0d integral=%0d, got %0d %0d %0d",
                     $realtime, want.drive, want.speed_error, want.integral_value,
                     out_ch.drive, out_ch.speed_error, out_ch.integral_value);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_addr                = '0;
    cfg_wdata               = '0;
    in_ch.valid             = 1'b0;
    in_ch.operation         = OP_TICK;
    in_ch.speed_setpoint    = '0;
    in_ch.measured_velocity = '0;
    src_calm                = 1'b0;
    snk_calm                = 1'b0;
    ticks_sent              = 0;
    reset_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_config();
    test_error_rounding();
    test_integral_band();
    test_limit_lowering();
    test_extreme_gains();
    test_random_ticks();

    wait_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
